FILE: sv/lob_pkg.sv
// Shared types, sizes and codes for the limit order book matcher.
package lob_pkg;

  localparam int ORDER_SLOTS  = 32;
  localparam int PRICE_BITS   = 8;
  localparam int QTY_BITS     = 16;
  localparam int ID_BITS      = 16;
  localparam int SLOT_W       = $clog2(ORDER_SLOTS);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_FILLED    = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_MODIFIED  = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_REJECTED  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]            opcode;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   quantity;
    logic [ID_BITS-1:0]    target_id;
  } in_word_t;

  typedef struct packed {
    kind_e                 kind;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_qty;
    logic [ID_BITS-1:0]    buy_id;
    logic [ID_BITS-1:0]    sell_id;
    logic [ID_BITS-1:0]    subject_id;
    logic [QTY_BITS-1:0]   remaining_qty;
    logic                  last;
  } out_word_t;

  // classified command handed from the front queue to the engine
  typedef struct packed {
    logic     valid;
    op_e      cls;
    in_word_t word;
  } cmd_t;

endpackage

FILE: sv/lob_front.sv
// Front end: accepts input words, classifies them and queues them for the engine.
module lob_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lob_pkg::in_word_t in_word_i,
  output lob_pkg::cmd_t     cmd_o,
  input  logic              pop_i
);
  import lob_pkg::*;

  op_e        cls_q [2];
  in_word_t   word_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cls   = cls_q[rd_ptr_q];
  assign cmd_o.word  = word_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      word_q[wr_ptr_q] <= in_word_i;
      unique case (in_word_i.opcode)
        OP_ADD:    cls_q[wr_ptr_q] <= OP_ADD;
        OP_CANCEL: cls_q[wr_ptr_q] <= OP_CANCEL;
        OP_MODIFY: cls_q[wr_ptr_q] <= OP_MODIFY;
        default:   cls_q[wr_ptr_q] <= OP_BAD;
      endcase
    end
  end

endmodule

FILE: sv/lob_engine.sv
// Back end: order slots, age matrix, scanning matcher and result register.
module lob_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lob_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lob_pkg::out_word_t out_word_o
);
  import lob_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIND   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_TRADE  = 3'd4;
  localparam logic [2:0] ST_FINAL  = 3'd5;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ORDER_SLOTS - 1);

  // slot storage
  logic [ORDER_SLOTS-1:0] valid_q;
  logic                   side_q  [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]  price_q [ORDER_SLOTS];
  logic [QTY_BITS-1:0]    qty_q   [ORDER_SLOTS];
  logic [ID_BITS-1:0]     ident_q [ORDER_SLOTS];
  // older_q[a][b] set: slot a arrived before slot b
  logic [ORDER_SLOTS-1:0] older_q [ORDER_SLOTS];

  logic [2:0]            state_q, state_d;
  logic [SLOT_W-1:0]     j_q, j_d;
  logic                  have_q, have_d;
  logic [SLOT_W-1:0]     best_q, best_d;
  logic [PRICE_BITS-1:0] bprice_q, bprice_d;
  logic [QTY_BITS-1:0]   bqty_q, bqty_d;
  logic [ID_BITS-1:0]    bident_q, bident_d;
  logic                  bside_q, bside_d;
  op_e                   op_q, op_d;
  logic                  wside_q, wside_d;
  logic [PRICE_BITS-1:0] wprice_q, wprice_d;
  logic [QTY_BITS-1:0]   qin_q, qin_d;
  logic [QTY_BITS-1:0]   left_q, left_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [ID_BITS-1:0]    id_ctr_q, id_ctr_d;
  kind_e                 kind_q, kind_d;
  logic [QTY_BITS-1:0]   rem_q, rem_d;

  logic                  out_valid_q;
  out_word_t             out_word_q;
  logic                  emit;
  out_word_t             emit_word;
  logic                  emit_ok;

  logic                  clr_en, qwr_en, rest_en;
  logic [SLOT_W-1:0]     wr_idx;
  logic [QTY_BITS-1:0]   qwr_val;
  logic                  free_any;
  logic [SLOT_W-1:0]     free_idx;
  logic                  cand, better;
  logic [QTY_BITS-1:0]   tq;

  assign emit_ok     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = ORDER_SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    cand = valid_q[j_q] && (side_q[j_q] != wside_q) &&
           (wside_q ? (price_q[j_q] >= wprice_q) : (price_q[j_q] <= wprice_q));
    better = !have_q ||
             (wside_q ? (price_q[j_q] > bprice_q) : (price_q[j_q] < bprice_q)) ||
             ((price_q[j_q] == bprice_q) && older_q[j_q][best_q]);
    tq = (left_q < bqty_q) ? left_q : bqty_q;
  end

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    have_d   = have_q;
    best_d   = best_q;
    bprice_d = bprice_q;
    bqty_d   = bqty_q;
    bident_d = bident_q;
    bside_d  = bside_q;
    op_d     = op_q;
    wside_d  = wside_q;
    wprice_d = wprice_q;
    qin_d    = qin_q;
    left_d   = left_q;
    id_d     = id_q;
    id_ctr_d = id_ctr_q;
    kind_d   = kind_q;
    rem_d    = rem_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    emit_word = '0;
    clr_en   = 1'b0;
    qwr_en   = 1'b0;
    rest_en  = 1'b0;
    wr_idx   = best_q;
    qwr_val  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          pop_o    = 1'b1;
          op_d     = cmd_i.cls;
          wside_d  = cmd_i.word.side;
          wprice_d = cmd_i.word.price;
          qin_d    = cmd_i.word.quantity;
          left_d   = cmd_i.word.quantity;
          j_d      = '0;
          have_d   = 1'b0;
          unique case (cmd_i.cls)
            OP_ADD: begin
              id_d     = id_ctr_q;
              id_ctr_d = id_ctr_q + ID_BITS'(1);
              state_d  = ST_SCAN;
            end
            OP_CANCEL, OP_MODIFY: begin
              id_d    = cmd_i.word.target_id;
              state_d = ST_FIND;
            end
            default: begin
              id_d    = cmd_i.word.target_id;
              kind_d  = KIND_NOT_FOUND;
              rem_d   = '0;
              state_d = ST_FINAL;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (!have_q && valid_q[j_q] && (ident_q[j_q] == id_q)) begin
          have_d   = 1'b1;
          best_d   = j_q;
          bprice_d = price_q[j_q];
          bqty_d   = qty_q[j_q];
          bside_d  = side_q[j_q];
        end
        if (j_q == LAST_SLOT) state_d = ST_DECIDE;
        else j_d = j_q + SLOT_W'(1);
      end
      ST_DECIDE: begin
        state_d = ST_FINAL;
        rem_d   = '0;
        if (!have_q) begin
          kind_d = KIND_NOT_FOUND;
        end else if ((op_q == OP_CANCEL) || (qin_q == '0)) begin
          clr_en = 1'b1;
          kind_d = KIND_CANCELLED;
        end else if ((wprice_q == bprice_q) && (qin_q <= bqty_q)) begin
          qwr_en  = 1'b1;
          qwr_val = qin_q;
          kind_d  = KIND_MODIFIED;
          rem_d   = qin_q;
        end else begin
          // re-add with the same id and the resting side
          clr_en  = 1'b1;
          wside_d = bside_q;
          left_d  = qin_q;
          j_d     = '0;
          have_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (left_q == '0) begin
          kind_d  = KIND_FILLED;
          rem_d   = '0;
          state_d = ST_FINAL;
        end else begin
          if (cand && better) begin
            have_d   = 1'b1;
            best_d   = j_q;
            bprice_d = price_q[j_q];
            bqty_d   = qty_q[j_q];
            bident_d = ident_q[j_q];
          end
          if (j_q == LAST_SLOT) state_d = ST_TRADE;
          else j_d = j_q + SLOT_W'(1);
        end
      end
      ST_TRADE: begin
        if (!have_q) begin
          rem_d   = left_q;
          state_d = ST_FINAL;
          if (free_any) begin
            rest_en = 1'b1;
            wr_idx  = free_idx;
            kind_d  = KIND_RESTED;
          end else begin
            kind_d  = KIND_REJECTED;
          end
        end else if (emit_ok) begin
          emit                    = 1'b1;
          emit_word.kind          = KIND_TRADE;
          emit_word.trade_price   = bprice_q;
          emit_word.trade_qty     = tq;
          emit_word.buy_id        = wside_q ? bident_q : id_q;
          emit_word.sell_id       = wside_q ? id_q : bident_q;
          emit_word.subject_id    = id_q;
          emit_word.remaining_qty = left_q - tq;
          qwr_en  = 1'b1;
          qwr_val = bqty_q - tq;
          clr_en  = (bqty_q == tq);
          left_d  = left_q - tq;
          j_d     = '0;
          have_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_FINAL: begin
        if (emit_ok) begin
          emit                    = 1'b1;
          emit_word.kind          = kind_q;
          emit_word.subject_id    = id_q;
          emit_word.remaining_qty = rem_q;
          emit_word.last          = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      id_ctr_q    <= ID_BITS'(1);
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q  <= state_d;
      id_ctr_q <= id_ctr_d;
      have_q   <= have_d;
      j_q      <= j_d;
      if (clr_en)  valid_q[wr_idx] <= 1'b0;
      if (rest_en) valid_q[wr_idx] <= 1'b1;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    bprice_q <= bprice_d;
    bqty_q   <= bqty_d;
    bident_q <= bident_d;
    bside_q  <= bside_d;
    op_q     <= op_d;
    wside_q  <= wside_d;
    wprice_q <= wprice_d;
    qin_q    <= qin_d;
    left_q   <= left_d;
    id_q     <= id_d;
    kind_q   <= kind_d;
    rem_q    <= rem_d;
    if (emit) out_word_q <= emit_word;
    if (qwr_en) qty_q[wr_idx] <= qwr_val;
    if (rest_en) begin
      side_q[wr_idx]  <= wside_q;
      price_q[wr_idx] <= wprice_q;
      qty_q[wr_idx]   <= left_q;
      ident_q[wr_idx] <= id_q;
      // new arrival is younger than every other slot
      older_q[wr_idx] <= '0;
      for (int k = 0; k < ORDER_SLOTS; k++) begin
        if (SLOT_W'(k) != wr_idx) older_q[k][wr_idx] <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/limit_order_book_matcher.sv
// Top level: price-time priority limit order book matcher.
// An accepted word is popped from the queue, then a 32-slot pass, a decide or rest step and
// the final status word; a modify that re-adds runs a second pass. Each trade that leaves
// the order open starts a new pass; the fill that completes it goes from the scan to final.
// The engine holds one word at a time, plus any output stall; the 2-deep front queue
// keeps accepting meanwhile. Reset: book empty, next id 1, ready right after reset.
module limit_order_book_matcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lob_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lob_pkg::out_word_t out_word_o
);
  import lob_pkg::*;

  cmd_t cmd;
  logic pop;

  lob_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cmd_o      (cmd),
    .pop_i      (pop)
  );

  lob_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: sv/lob_checker.sv
// Port-level checks for the order book matcher, bound to the top level.
module lob_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lob_pkg::out_word_t out_word_o
);
  import lob_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_trade_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_TRADE) |-> !out_word_o.last)
    else $error("trade flagged last");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind != KIND_TRADE) |->
      out_word_o.last && (out_word_o.trade_qty == '0) &&
      (out_word_o.buy_id == '0) && (out_word_o.sell_id == '0))
    else $error("status word malformed");

  a_trade_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_TRADE) |-> (out_word_o.trade_qty != '0))
    else $error("empty trade");

endmodule

bind limit_order_book_matcher lob_port_checks u_lob_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
